/* rtl/core/bae_pkg.sv */
// Shared types and codes for the bounded array engine.
// No dependencies; used by the top level and its port checker.
`default_nettype none
package bae_pkg;
   typedef enum logic [3:0] {
      CMD_APPEND  = 4'd0,
      CMD_INSERT  = 4'd1,
      CMD_DELETE  = 4'd2,
      CMD_GET     = 4'd3,
      CMD_SET     = 4'd4,
      CMD_LSEARCH = 4'd5,
      CMD_BSEARCH = 4'd6,
      CMD_MAX     = 4'd7,
      CMD_MIN     = 4'd8,
      CMD_REVERSE = 4'd9,
      CMD_ROTATE  = 4'd10
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 48;
endpackage
`default_nettype wire

/* rtl/core/bounded_array_engine.sv */
// Bounded array engine: up to CAPACITY signed words in one synchronous RAM.
// Depends on bae_pkg for command and status codes.
//
// Usage: one request beat on req_* carries a command; exactly one response
// beat on rsp_* follows with the result, status and new length. The store
// lives in a single RAM with one write and one registered read port, so
// every element visit waits on a registered RAM read. Append, set and invalid
// codes go straight to the response; get adds one RAM read. Insert and delete
// shift one element per read and write, linear search and max/min read each
// element visited, binary search reads once per probe. Reverse reads both
// ends of each pair, then writes both; rotate first reduces the count by
// repeated subtraction of the length and then runs three reversals.
// One command is worked at a time; req_tready is high only while idle.
// A finished response waits in the output register, and the next request
// is taken meanwhile; if that one finishes while the response is still
// stalled, the engine holds until rsp_tready.
// Reset clears the length and the response valid; the RAM is not cleared
// since no entry at or beyond the length is ever read.
`default_nettype none
module bounded_array_engine #(
   parameter int CAPACITY = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // tdata: index[5:0], value[37:6], key[69:38], count[77:70], zero[79:78]
   input  wire logic [bae_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: cmd[3:0]
   input  wire logic [3:0]                     req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // tdata: result_value[31:0], position[36:32], found[37], status[39:38],
   // length_now[45:40], zero[47:46]
   output logic [bae_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   localparam int AW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int CW = (LW > 8) ? LW : 8;

   typedef enum logic [15:0] {
      S_IDLE = 16'h0001,
      S_SHRD = 16'h0002,
      S_SHWR = 16'h0004,
      S_DLRD = 16'h0008,
      S_DLWR = 16'h0010,
      S_GET  = 16'h0020,
      S_SCAN = 16'h0040,
      S_SCHK = 16'h0080,
      S_BRD  = 16'h0100,
      S_BCHK = 16'h0200,
      S_MOD  = 16'h0400,
      S_RVA  = 16'h0800,
      S_RVB  = 16'h1000,
      S_RVW1 = 16'h2000,
      S_RVW2 = 16'h4000,
      S_FIN  = 16'h8000
   } state_type;

   state_type state_ff, state_in;
   logic [LW-1:0] n_ff, n_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [bae_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [3:0] op_ff, op_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [31:0] val_ff, val_in;
   logic [31:0] key_ff, key_in;
   logic [7:0] rem_ff, rem_in;
   logic [CW-1:0] pa_ff, pa_in;
   logic [CW-1:0] pb_ff, pb_in;
   logic signed [CW:0] lo_ff, lo_in;
   logic signed [CW:0] hi_ff, hi_in;
   logic [1:0] phase_ff, phase_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] tmp_ff, tmp_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic fnd_ff, fnd_in;
   bae_pkg::status_type st_ff, st_in;

   logic [31:0] mem [CAPACITY];
   logic [31:0] mem_rdata_ff;
   logic mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [31:0] mem_wdata;

   logic [CW-1:0] n_ext, r_ext, req_idx, req_cnt;
   logic signed [CW+1:0] mid_sum;
   logic [CW-1:0] mid;
   logic accept;

   assign n_ext = CW'(n_ff);
   assign r_ext = CW'(rem_ff);
   assign req_idx = CW'(req_tdata[5:0]);
   assign req_cnt = CW'(req_tdata[77:70]);
   assign mid_sum = (CW+2)'(lo_ff) + (CW+2)'(hi_ff);
   assign mid = mid_sum[CW:1];
   assign req_tready = (state_ff == S_IDLE);
   assign accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      n_in = n_ff;
      op_in = op_ff;
      idx_in = idx_ff;
      val_in = val_ff;
      key_in = key_ff;
      rem_in = rem_ff;
      pa_in = pa_ff;
      pb_in = pb_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      phase_in = phase_ff;
      acc_in = acc_ff;
      tmp_in = tmp_ff;
      pos_in = pos_ff;
      fnd_in = fnd_ff;
      st_in = st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      mem_we = 1'b0;
      mem_re = 1'b0;
      mem_waddr = '0;
      mem_raddr = '0;
      mem_wdata = val_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req_tuser;
               idx_in = req_idx;
               val_in = req_tdata[37:6];
               key_in = req_tdata[69:38];
               rem_in = req_tdata[77:70];
               acc_in = '0;
               pos_in = '0;
               fnd_in = 1'b0;
               st_in = bae_pkg::ST_OK;
               state_in = S_FIN;
               case (req_tuser)
                  bae_pkg::CMD_APPEND: begin
                     if (n_ext >= CW'(CAPACITY)) begin
                        st_in = bae_pkg::ST_FULL;
                     end else begin
                        mem_we = 1'b1;
                        mem_waddr = n_ext[AW-1:0];
                        mem_wdata = req_tdata[37:6];
                        n_in = n_ff + 1'b1;
                     end
                  end
                  bae_pkg::CMD_INSERT: begin
                     if (req_idx > n_ext) begin
                        st_in = bae_pkg::ST_RANGE;
                     end else if (n_ext >= CW'(CAPACITY)) begin
                        st_in = bae_pkg::ST_FULL;
                     end else begin
                        pa_in = n_ext;
                        state_in = S_SHRD;
                     end
                  end
                  bae_pkg::CMD_DELETE, bae_pkg::CMD_GET, bae_pkg::CMD_SET: begin
                     if (n_ext == '0) begin
                        st_in = bae_pkg::ST_EMPTY;
                     end else if (req_idx >= n_ext) begin
                        st_in = bae_pkg::ST_RANGE;
                     end else if (req_tuser == bae_pkg::CMD_DELETE) begin
                        pa_in = req_idx;
                        state_in = S_DLRD;
                     end else if (req_tuser == bae_pkg::CMD_GET) begin
                        mem_re = 1'b1;
                        mem_raddr = req_idx[AW-1:0];
                        state_in = S_GET;
                     end else begin
                        mem_we = 1'b1;
                        mem_waddr = req_idx[AW-1:0];
                        mem_wdata = req_tdata[37:6];
                     end
                  end
                  bae_pkg::CMD_LSEARCH: begin
                     if (n_ext != '0) begin
                        pa_in = '0;
                        state_in = S_SCAN;
                     end
                  end
                  bae_pkg::CMD_BSEARCH: begin
                     lo_in = '0;
                     hi_in = $signed({1'b0, n_ext}) - 2'sd1;
                     state_in = S_BRD;
                  end
                  bae_pkg::CMD_MAX, bae_pkg::CMD_MIN: begin
                     if (n_ext == '0) begin
                        st_in = bae_pkg::ST_EMPTY;
                     end else begin
                        pa_in = '0;
                        state_in = S_SCAN;
                     end
                  end
                  bae_pkg::CMD_REVERSE: begin
                     if (n_ext >= CW'(2)) begin
                        phase_in = 2'd2;
                        pa_in = '0;
                        pb_in = n_ext - 1'b1;
                        state_in = S_RVA;
                     end
                  end
                  bae_pkg::CMD_ROTATE: begin
                     if (n_ext == '0) begin
                        st_in = bae_pkg::ST_EMPTY;
                     end else begin
                        state_in = S_MOD;
                     end
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_SHRD: begin
            if (pa_ff > idx_ff) begin
               mem_re = 1'b1;
               mem_raddr = AW'(pa_ff - 1'b1);
               state_in = S_SHWR;
            end else begin
               mem_we = 1'b1;
               mem_waddr = idx_ff[AW-1:0];
               n_in = n_ff + 1'b1;
               state_in = S_FIN;
            end
         end
         S_SHWR: begin
            mem_we = 1'b1;
            mem_waddr = pa_ff[AW-1:0];
            mem_wdata = mem_rdata_ff;
            pa_in = pa_ff - 1'b1;
            state_in = S_SHRD;
         end
         S_DLRD: begin
            if (pa_ff + 1'b1 < n_ext) begin
               mem_re = 1'b1;
               mem_raddr = AW'(pa_ff + 1'b1);
               state_in = S_DLWR;
            end else begin
               n_in = n_ff - 1'b1;
               state_in = S_FIN;
            end
         end
         S_DLWR: begin
            mem_we = 1'b1;
            mem_waddr = pa_ff[AW-1:0];
            mem_wdata = mem_rdata_ff;
            pa_in = pa_ff + 1'b1;
            state_in = S_DLRD;
         end
         S_GET: begin
            acc_in = mem_rdata_ff;
            state_in = S_FIN;
         end
         S_SCAN: begin
            mem_re = 1'b1;
            mem_raddr = pa_ff[AW-1:0];
            state_in = S_SCHK;
         end
         S_SCHK: begin
            pa_in = pa_ff + 1'b1;
            state_in = (pa_ff + 1'b1 < n_ext) ? S_SCAN : S_FIN;
            if (op_ff == bae_pkg::CMD_LSEARCH) begin
               if (mem_rdata_ff == key_ff) begin
                  fnd_in = 1'b1;
                  pos_in = pa_ff;
                  state_in = S_FIN;
               end
            end else if (pa_ff == '0) begin
               acc_in = mem_rdata_ff;
            end else if (op_ff == bae_pkg::CMD_MAX) begin
               if ($signed(acc_ff) < $signed(mem_rdata_ff)) begin
                  acc_in = mem_rdata_ff;
               end
            end else if ($signed(mem_rdata_ff) < $signed(acc_ff)) begin
               acc_in = mem_rdata_ff;
            end
         end
         S_BRD: begin
            if (lo_ff <= hi_ff) begin
               mem_re = 1'b1;
               mem_raddr = mid[AW-1:0];
               pa_in = mid;
               state_in = S_BCHK;
            end else begin
               state_in = S_FIN;
            end
         end
         S_BCHK: begin
            state_in = S_BRD;
            if (mem_rdata_ff == key_ff) begin
               fnd_in = 1'b1;
               pos_in = pa_ff;
               state_in = S_FIN;
            end else if ($signed(mem_rdata_ff) < $signed(key_ff)) begin
               lo_in = $signed({1'b0, pa_ff}) + 2'sd1;
            end else begin
               hi_in = $signed({1'b0, pa_ff}) - 2'sd1;
            end
         end
         S_MOD: begin
            if (r_ext >= n_ext) begin
               rem_in = 8'(r_ext - n_ext);
            end else if (rem_ff == '0) begin
               state_in = S_FIN;
            end else begin
               phase_in = 2'd0;
               pa_in = '0;
               pb_in = r_ext - 1'b1;
               state_in = S_RVA;
            end
         end
         S_RVA: begin
            if (pa_ff < pb_ff) begin
               mem_re = 1'b1;
               mem_raddr = pa_ff[AW-1:0];
               state_in = S_RVB;
            end else if (phase_ff == 2'd0) begin
               phase_in = 2'd1;
               pa_in = r_ext;
               pb_in = n_ext - 1'b1;
            end else if (phase_ff == 2'd1) begin
               phase_in = 2'd2;
               pa_in = '0;
               pb_in = n_ext - 1'b1;
            end else begin
               state_in = S_FIN;
            end
         end
         S_RVB: begin
            tmp_in = mem_rdata_ff;
            mem_re = 1'b1;
            mem_raddr = pb_ff[AW-1:0];
            state_in = S_RVW1;
         end
         S_RVW1: begin
            mem_we = 1'b1;
            mem_waddr = pa_ff[AW-1:0];
            mem_wdata = mem_rdata_ff;
            state_in = S_RVW2;
         end
         S_RVW2: begin
            mem_we = 1'b1;
            mem_waddr = pb_ff[AW-1:0];
            mem_wdata = tmp_ff;
            pa_in = pa_ff + 1'b1;
            pb_in = pb_ff - 1'b1;
            state_in = S_RVA;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {2'b00, n_ext[5:0], st_ff, fnd_ff, pos_ff[4:0], acc_ff};
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         n_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      op_ff <= op_in;
      idx_ff <= idx_in;
      val_ff <= val_in;
      key_ff <= key_in;
      rem_ff <= rem_in;
      pa_ff <= pa_in;
      pb_ff <= pb_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      phase_ff <= phase_in;
      acc_ff <= acc_in;
      tmp_ff <= tmp_in;
      pos_ff <= pos_in;
      fnd_ff <= fnd_in;
      st_ff <= st_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= mem[mem_raddr];
      end
   end
endmodule
`default_nettype wire

/* rtl/core/bae_checker.sv */
// Port-level checker for the bounded array engine, bound to the top level.
// Depends on bae_pkg for status codes.
`default_nettype none
module bae_checker #(
   parameter int CAPACITY = 32
) (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic [bae_pkg::REQ_DATA_W-1:0] req_tdata,
   input wire logic [3:0]                     req_tuser,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [bae_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   localparam logic [6:0] CAP_MOD = 7'(CAPACITY % 64);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response beat right after reset");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (CAPACITY >= 64) || ({1'b0, rsp_tdata[45:40]} <= CAP_MOD))
      else $error("length beyond capacity");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[39:38] == bae_pkg::ST_FULL
      |-> {1'b0, rsp_tdata[45:40]} == CAP_MOD)
      else $error("full status with room left");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[37] |-> rsp_tdata[39:38] == bae_pkg::ST_OK
      && rsp_tdata[31:0] == 32'd0)
      else $error("found flag with error status or value");
endmodule

bind bounded_array_engine bae_checker #(.CAPACITY(CAPACITY)) u_bae_checker (.*);
`default_nettype wire
